// ----- sv/ses_pkg.sv -----
// Package for the saturation equilibrium solver: widths, codes, command/status structs.
// No dependencies.
package ses_pkg;

    localparam int FRAC_W = 32;
    localparam int SUM_W  = 40;
    localparam int TOL_W  = 29;
    localparam int ITER_W = 16;
    localparam int FACE_W = 16;
    localparam int IDX_W  = 3;

    localparam logic OP_ACTIVE   = 1'b0;
    localparam logic OP_INACTIVE = 1'b1;

    localparam logic [0:0] REG_TOLERANCE = 1'b0;
    localparam logic [0:0] REG_MAX_ITER  = 1'b1;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 29'd3;
    localparam logic [ITER_W-1:0] ITER_RESET = 16'd1000;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // controller -> datapath
    typedef struct packed {
        logic clear_sums;   // start of a round: load SumX with the inactive sum, zero SumW/abs sum
        logic acc_sums;     // add entry idx into SumX/SumW
        logic sat_sums;     // saturate SumX/SumW
        logic calc_p;       // p = SumX*s >> 16 for entry idx
        logic div_start;    // start the divider
        logic calc_t;       // t*q product
        logic calc_dx;      // dx and abs accumulate
        logic update;       // x += dx, w -= dx for entry idx
        logic test_conv;    // register convergence compare
    } ses_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic conv_hit;
    } ses_sts_t;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

endpackage

// ----- sv/ses_div.sv -----
// Radix-2 restoring divider: q = num*2^28/den, truncated, saturated to 32-bit signed.
// Depends on ses_pkg.
module ses_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    import ses_pkg::*;

    localparam logic [6:0]         LAST_STEP = 7'd91;
    localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;

    logic [63:0]        n_abs, d_abs;
    logic               neg;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               neg_reg, neg_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [63:0]        num_reg, num_next;
    logic [63:0]        den_reg, den_next;
    logic [63:0]        rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic               ovf_reg, ovf_next;
    logic signed [31:0] quot_reg, quot_next;
    logic [64:0]        trial;
    logic               qbit;

    assign neg   = num[63] ^ den[63];
    assign n_abs = num[63] ? 64'(-num) : 64'(num);
    assign d_abs = den[63] ? 64'(-den) : 64'(den);

    // one quotient bit a cycle: 64 dividend bits, then 28 zero bits for the fraction
    assign trial = {rem_reg, num_reg[63]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        quot_next = quot_reg;
        if (start) begin
            neg_next = neg;
            den_next = d_abs;
            num_next = n_abs;
            rem_next = '0;
            quo_next = '0;
            ovf_next = 1'b0;
            cnt_next = '0;
            if (d_abs == 64'd0) begin
                // divide by zero: zero for a zero numerator, else saturate by its sign
                busy_next = 1'b0;
                done_next = 1'b1;
                if (num == 64'sd0)  quot_next = '0;
                else if (num[63])   quot_next = Q_MIN;
                else                quot_next = Q_MAX;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = qbit ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
            num_next = {num_reg[62:0], 1'b0};
            quo_next = {quo_reg[30:0], qbit};
            // keep a sticky flag once the quotient no longer fits 31 bits
            ovf_next = ovf_reg | quo_reg[31];
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (ovf_next | quo_next[31]) quot_next = neg_reg ? Q_MIN : Q_MAX;
                else quot_next = neg_reg ? -$signed(quo_next) : $signed(quo_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            ovf_reg  <= 1'b0;
            quot_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            cnt_reg  <= cnt_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            ovf_reg  <= ovf_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- sv/ses_datapath.sv -----
// Datapath: species stores, sums, per-entry step arithmetic and result fields.
// Depends on ses_pkg and ses_div.
module ses_datapath #(
    parameter int MAX_ACTIVE = 8,
    parameter int CW = $clog2(MAX_ACTIVE + 1),
    parameter int AW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ses_pkg::ses_cmd_t      cmd,
    output ses_pkg::ses_sts_t      sts,
    input  logic                   ld_we,
    input  logic [AW-1:0]          ld_addr,
    input  logic signed [31:0]     ld_x,
    input  logic signed [31:0]     ld_w,
    input  logic [31:0]            ld_s,
    input  logic [AW-1:0]          idx,
    input  logic [CW-1:0]          count,
    input  logic signed [39:0]     inactive_sum,
    input  logic [28:0]            tolerance,
    output logic signed [31:0]     rd_x,
    output logic signed [31:0]     rd_w
);
    import ses_pkg::*;

    logic signed [31:0] x_mem [MAX_ACTIVE];
    logic signed [31:0] w_mem [MAX_ACTIVE];
    logic [31:0]        s_mem [MAX_ACTIVE];
    logic signed [31:0] dx_mem [MAX_ACTIVE];

    logic signed [63:0] sx_reg, sw_reg, p_reg, tq_reg;
    logic signed [31:0] t_reg, q_div, dx_val;
    logic [63:0]        sabs_reg;
    logic               div_done;
    logic signed [64:0] sxs_prod;
    logic signed [63:0] tq_prod;
    logic [32:0]        tol_n;

    // stores: load port and in-place update
    always_ff @(posedge aclk) begin
        if (ld_we) begin
            x_mem[ld_addr] <= ld_x;
            w_mem[ld_addr] <= ld_w;
            s_mem[ld_addr] <= ld_s;
        end else if (cmd.update) begin
            x_mem[idx] <= 32'(sat32(64'(x_mem[idx]) + 64'(dx_mem[idx])));
            w_mem[idx] <= 32'(sat32(64'(w_mem[idx]) - 64'(dx_mem[idx])));
        end
    end

    assign rd_x = x_mem[idx];
    assign rd_w = w_mem[idx];

    // saturated SumX times saturation, t times q, and the step of entry idx
    assign sxs_prod = $signed(sx_reg[31:0]) * $signed({1'b0, s_mem[idx]});
    assign tq_prod  = t_reg * q_div;
    assign dx_val   = 32'(sat32((tq_reg >>> 28) - 64'(x_mem[idx])));
    assign tol_n    = tolerance * count;

    // sums, products and step
    always_ff @(posedge aclk) begin
        if (cmd.clear_sums) begin
            sx_reg   <= 64'(inactive_sum);
            sw_reg   <= '0;
            sabs_reg <= '0;
        end
        if (cmd.acc_sums) begin
            sx_reg <= sx_reg + 64'(x_mem[idx]);
            sw_reg <= sw_reg + 64'(w_mem[idx]);
        end
        if (cmd.sat_sums) begin
            sx_reg <= sat32(sx_reg);
            sw_reg <= sat32(sw_reg);
        end
        if (cmd.calc_p) begin
            p_reg <= 64'(sxs_prod >>> 16);
            t_reg <= 32'(sat32(64'(x_mem[idx]) + 64'(w_mem[idx])));
        end
        if (cmd.calc_t) begin
            tq_reg <= tq_prod;
        end
        if (cmd.calc_dx) begin
            dx_mem[idx] <= dx_val;
            sabs_reg <= sabs_reg + (dx_val[31] ? 64'(-64'(dx_val)) : 64'(dx_val));
        end
    end

    ses_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (p_reg),
        .den     (sw_reg + p_reg),
        .done    (div_done),
        .quot    (q_div)
    );

    logic conv_reg;
    always_ff @(posedge aclk) begin
        if (cmd.test_conv)
            conv_reg <= (sabs_reg < 64'(tol_n));
    end

    assign sts.div_done = div_done;
    assign sts.conv_hit = conv_reg;

endmodule

// ----- sv/ses_ctrl.sv -----
// Controller: load, iterate, emit sequencer for the solver.
// Depends on ses_pkg.
module ses_ctrl #(
    parameter int MAX_ACTIVE = 8,
    parameter int CW = $clog2(MAX_ACTIVE + 1),
    parameter int AW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_op,
    input  logic [15:0]       in_face,
    input  logic signed [31:0] in_x,
    input  logic              in_last,
    output logic              ld_we,
    output logic [AW-1:0]     ld_addr,
    output ses_pkg::ses_cmd_t cmd,
    input  ses_pkg::ses_sts_t sts,
    output logic [AW-1:0]     idx,
    output logic [CW-1:0]     count,
    output logic signed [39:0] inactive_sum,
    input  logic [15:0]       max_iter,
    input  logic signed [31:0] rd_x,
    input  logic signed [31:0] rd_w,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       out_face,
    output logic [2:0]        out_idx,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_w,
    output logic              out_conv,
    output logic              out_final
);
    import ses_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_ROUND, S_SUM, S_SAT, S_P, S_DIVGO, S_DIVWAIT, S_TQ, S_DX,
        S_TEST, S_DECIDE, S_UPD, S_EMIT, S_HOLD
    } state_t;

    state_t state_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] j_reg;
    logic signed [39:0] isum_reg;
    logic [15:0] face_reg, iter_reg;
    logic conv_flag_reg;
    logic signed [40:0] isum_add;

    localparam logic signed [40:0] SUM40_MAX = 41'sd549755813887;
    localparam logic signed [40:0] SUM40_MIN = -41'sd549755813888;

    assign in_ready     = (state_reg == S_LOAD);
    assign ld_we        = in_valid && in_ready && (in_op == OP_ACTIVE) &&
                          (cnt_reg < CW'(MAX_ACTIVE));
    assign ld_addr      = cnt_reg[AW-1:0];
    assign idx          = j_reg[AW-1:0];
    assign count        = cnt_reg;
    assign inactive_sum = isum_reg;
    assign isum_add     = 41'(isum_reg) + 41'(in_x);

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_ROUND:   cmd.clear_sums = 1'b1;
            S_SUM:     cmd.acc_sums   = 1'b1;
            S_SAT:     cmd.sat_sums   = 1'b1;
            S_P:       cmd.calc_p     = 1'b1;
            S_DIVGO:   cmd.div_start  = 1'b1;
            S_TQ:      cmd.calc_t     = 1'b1;
            S_DX:      cmd.calc_dx    = 1'b1;
            S_TEST:    cmd.test_conv  = 1'b1;
            S_UPD:     cmd.update     = 1'b1;
            default:   cmd = '0;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            isum_reg  <= '0;
            face_reg  <= '0;
            iter_reg  <= '0;
            j_reg     <= '0;
            out_valid <= 1'b0;
            conv_flag_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_LOAD: if (in_valid) begin
                    face_reg <= in_face;
                    if (ld_we) cnt_reg <= cnt_reg + CW'(1);
                    if (in_op == OP_INACTIVE) begin
                        if (isum_add > SUM40_MAX)      isum_reg <= 40'(SUM40_MAX);
                        else if (isum_add < SUM40_MIN) isum_reg <= 40'(SUM40_MIN);
                        else                           isum_reg <= 40'(isum_add);
                    end
                    if (in_last) begin
                        iter_reg <= '0;
                        conv_flag_reg <= 1'b0;
                        j_reg <= '0;
                        if (cnt_reg == '0 && !ld_we) begin
                            state_reg <= S_EMIT;
                            out_valid <= 1'b1;
                            out_face  <= in_face;
                            out_idx   <= '0;
                            out_x     <= '0;
                            out_w     <= '0;
                            out_conv  <= 1'b0;
                            out_final <= 1'b1;
                        end else if (max_iter == 16'd0) begin
                            state_reg <= S_HOLD;
                        end else begin
                            state_reg <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    j_reg <= '0;
                    iter_reg <= iter_reg + 16'd1;
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    if (j_reg == cnt_reg - CW'(1)) begin
                        j_reg <= '0;
                        state_reg <= S_SAT;
                    end else j_reg <= j_reg + CW'(1);
                end
                S_SAT:     state_reg <= S_P;
                S_P:       state_reg <= S_DIVGO;
                S_DIVGO:   state_reg <= S_DIVWAIT;
                S_DIVWAIT: if (sts.div_done) state_reg <= S_TQ;
                S_TQ:      state_reg <= S_DX;
                S_DX: begin
                    if (j_reg == cnt_reg - CW'(1)) begin
                        j_reg <= '0;
                        state_reg <= S_TEST;
                    end else begin
                        j_reg <= j_reg + CW'(1);
                        state_reg <= S_P;
                    end
                end
                S_TEST:    state_reg <= S_DECIDE;
                S_DECIDE: begin
                    if (sts.conv_hit) begin
                        conv_flag_reg <= 1'b1;
                        state_reg <= S_HOLD;
                    end else state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (j_reg == cnt_reg - CW'(1)) begin
                        j_reg <= '0;
                        state_reg <= (iter_reg == max_iter) ? S_HOLD : S_ROUND;
                    end else j_reg <= j_reg + CW'(1);
                end
                S_HOLD: begin
                    // present entry j as a result
                    out_valid <= 1'b1;
                    out_face  <= face_reg;
                    out_idx   <= 3'(j_reg);
                    out_x     <= rd_x;
                    out_w     <= rd_w;
                    out_conv  <= conv_flag_reg;
                    out_final <= (j_reg == cnt_reg - CW'(1));
                    state_reg <= S_EMIT;
                end
                S_EMIT: if (out_ready) begin
                    out_valid <= 1'b0;
                    if (out_final) begin
                        cnt_reg  <= '0;
                        isum_reg <= '0;
                        state_reg <= S_LOAD;
                    end else begin
                        j_reg <= j_reg + CW'(1);
                        state_reg <= S_HOLD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // no new items are taken while results are pending
    assert property (@(posedge aclk) disable iff (!aresetn) out_valid |-> !in_ready)
        else $error("input accepted during emit");
    // store count never exceeds capacity
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= CW'(MAX_ACTIVE))
        else $error("active count overflow");
    // result held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_idx))
        else $error("result changed under stall");

endmodule

// ----- sv/saturation_equilibrium_solver_top.sv -----
// Saturation equilibrium solver.
// Channels: the s_axis stream carries species transactions (tuser is the opcode),
// the m_axis stream one result per stored active species (one zero result when
// there are none) after the transaction marked tlast (tuser is the converged flag).
// The APB port writes tolerance (address 0) and max_iterations (address 4).
// Solve: after the last load transaction a solve runs. Each species step waits on
// the divider (92 quotient bits, one a cycle), which skips the quotient bits when
// the divisor is zero. Each round sums the active species, steps each of them,
// tests for convergence and, when it does not converge, updates each species;
// rounds repeat up to max_iterations. Results then leave one at a time, each
// presented after the previous one is taken.
// One face at a time: s_axis_tready drops from the last item until the final
// result is taken. A stalled receiver holds the result and the whole block.
// Reset (aresetn low, synchronous) clears counts, the inactive sum and the face tag and
// restores tolerance 3 and max_iterations 1000. Stored species are undefined
// until loaded.
// Depends on ses_pkg, ses_ctrl, ses_datapath, ses_div.
module saturation_equilibrium_solver_top #(
    parameter int MAX_ACTIVE = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: face_number[15:0], mole_x[47:16], mole_w[79:48], saturation[111:80]
    input  logic [111:0] s_axis_tdata,
    // tuser: opcode[0]
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: face_tag[15:0], species_index[18:16], new_x[50:19], new_w[82:51],
    // zero fill
    output logic [87:0]  m_axis_tdata,
    // tuser: converged[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ses_pkg::*;

    localparam int CW = $clog2(MAX_ACTIVE + 1);
    localparam int AW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;

    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] maxit_reg;
    ses_cmd_t cmd;
    ses_sts_t sts;
    logic ld_we;
    logic [AW-1:0] ld_addr, idx;
    logic [CW-1:0] count;
    logic signed [39:0] isum;
    logic signed [31:0] rd_x, rd_w, o_x, o_w;
    logic [15:0] o_face;
    logic [2:0] o_idx;

    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg   <= TOL_RESET;
            maxit_reg <= ITER_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_TOLERANCE: tol_reg   <= pwdata[TOL_W-1:0];
                REG_MAX_ITER:  maxit_reg <= pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TOLERANCE: prdata = {3'd0, tol_reg};
            REG_MAX_ITER:  prdata = {16'd0, maxit_reg};
            default:       prdata = '0;
        endcase
    end

    ses_ctrl #(.MAX_ACTIVE(MAX_ACTIVE)) u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
        .in_op (s_axis_tuser), .in_face (s_axis_tdata[15:0]),
        .in_x (s_axis_tdata[47:16]), .in_last (s_axis_tlast),
        .ld_we, .ld_addr, .cmd, .sts, .idx, .count,
        .inactive_sum (isum), .max_iter (maxit_reg), .rd_x, .rd_w,
        .out_valid (m_axis_tvalid), .out_ready (m_axis_tready),
        .out_face (o_face), .out_idx (o_idx), .out_x (o_x), .out_w (o_w),
        .out_conv (m_axis_tuser), .out_final (m_axis_tlast)
    );

    ses_datapath #(.MAX_ACTIVE(MAX_ACTIVE)) u_dp (
        .aclk, .aresetn, .cmd, .sts, .ld_we, .ld_addr,
        .ld_x (s_axis_tdata[47:16]), .ld_w (s_axis_tdata[79:48]),
        .ld_s (s_axis_tdata[111:80]), .idx, .count,
        .inactive_sum (isum), .tolerance (tol_reg), .rd_x, .rd_w
    );

    assign m_axis_tdata = {5'd0, o_w, o_x, o_idx, o_face};

endmodule

// ----- sim/saturation_equilibrium_solver_top_test.sv -----
// Self-checking testbench for saturation_equilibrium_solver_top: directed table plus random faces,
// every result compared with a local fixed-point equilibrium predictor.
// Depends on ses_pkg and the solver RTL.
`timescale 1ns / 100ps

module saturation_equilibrium_solver_top_test;
    import ses_pkg::*;

    typedef struct {
        logic        opcode;
        logic [15:0] face;
        logic [31:0] mx;
        logic [31:0] mw;
        logic [31:0] sat;
        logic        last;
    } species_t;

    typedef struct {
        logic [15:0] face;
        logic [2:0]  idx;
        logic [31:0] nx;
        logic [31:0] nw;
        logic        conv;
        logic        fin;
    } solved_t;

    typedef struct {
        species_t item;
        bit       typed;
        solved_t  want;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    saturation_equilibrium_solver_top dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    longint      eq_x[8];
    longint      eq_w[8];
    logic [31:0] eq_s[8];
    int          eq_count;
    longint      eq_inact;
    logic [15:0] eq_face;
    logic [28:0] eq_tol;
    logic [15:0] eq_maxit;

    solved_t  solved_q[$];
    row_t     cur_row;
    int       err_count = 0;
    int       items_sent = 0;
    int       results_seen = 0;
    int       faces_sent = 0;
    int       snd_idle = 0;
    int       rcv_idle = 0;
    bit       hold_req = 0;
    int       hold_left = 0;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // (num * 2^28) / den toward zero, saturated
    function automatic longint q28_ratio(longint num, longint den);
        bit neg;
        longint unsigned n, d, lim, qi, r, res;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (d == 0) begin
            if (num == 0) return 0;
            return (num > 0) ? 64'sd2147483647 : -64'sd2147483648;
        end
        qi = n / d;
        if (qi >= 8) begin
            res = lim;
        end else begin
            r = n % d;
            res = qi;
            for (int i = 0; i < 28; i++) begin
                r = r << 1;
                res = res << 1;
                if (r >= d) begin
                    r = r - d;
                    res = res | 1;
                end
            end
            if (res > lim) res = lim;
        end
        return neg ? -longint'(res) : longint'(res);
    endfunction

    // Jacobi rounds on the stored species; returns convergence
    function automatic bit run_rounds();
        longint sx, sw, sabs, p, q, t;
        longint dx[8];
        for (int it = 0; it < eq_maxit; it++) begin
            sx = eq_inact;
            sw = 0;
            sabs = 0;
            for (int j = 0; j < eq_count; j++) begin
                sx += eq_x[j];
                sw += eq_w[j];
            end
            sx = clip32(sx);
            sw = clip32(sw);
            for (int j = 0; j < eq_count; j++) begin
                p = (sx * longint'({32'd0, eq_s[j]})) >>> 16;
                q = q28_ratio(p, sw + p);
                t = clip32(eq_x[j] + eq_w[j]);
                dx[j] = clip32(((t * q) >>> 28) - eq_x[j]);
                sabs += (dx[j] < 0) ? -dx[j] : dx[j];
            end
            if (sabs < longint'(eq_tol) * eq_count) return 1;
            for (int j = 0; j < eq_count; j++) begin
                eq_x[j] = clip32(eq_x[j] + dx[j]);
                eq_w[j] = clip32(eq_w[j] - dx[j]);
            end
        end
        return 0;
    endfunction

    // Load one species and queue the results of a solve
    function automatic void load_species(species_t it);
        bit conv;
        solved_t r;
        eq_face = it.face;
        if (it.opcode == OP_ACTIVE) begin
            if (eq_count < 8) begin
                eq_x[eq_count] = longint'($signed(it.mx));
                eq_w[eq_count] = longint'($signed(it.mw));
                eq_s[eq_count] = it.sat;
                eq_count++;
            end
        end else begin
            eq_inact += longint'($signed(it.mx));
            if (eq_inact > 64'sd549755813887) eq_inact = 64'sd549755813887;
            if (eq_inact < -64'sd549755813888) eq_inact = -64'sd549755813888;
        end
        if (!it.last) return;
        if (eq_count == 0) begin
            r = '{eq_face, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1};
            solved_q.push_back(r);
        end else begin
            conv = run_rounds();
            for (int j = 0; j < eq_count; j++) begin
                r.face = eq_face;
                r.idx = j[2:0];
                r.nx = eq_x[j][31:0];
                r.nw = eq_w[j][31:0];
                r.conv = conv;
                r.fin = (j + 1 == eq_count);
                solved_q.push_back(r);
            end
        end
        eq_count = 0;
        eq_inact = 0;
    endfunction

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        int n0;
        solved_t got, want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                n0 = solved_q.size();
                load_species(cur_row.item);
                if (cur_row.typed) begin
                    while (solved_q.size() > n0) void'(solved_q.pop_back());
                    solved_q.push_back(cur_row.want);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.face = m_axis_tdata[15:0];
                got.idx  = m_axis_tdata[18:16];
                got.nx   = m_axis_tdata[50:19];
                got.nw   = m_axis_tdata[82:51];
                got.conv = m_axis_tuser;
                got.fin  = m_axis_tlast;
                if (solved_q.size() == 0) begin
                    $error("unexpected result transaction face %h idx %0d", got.face, got.idx);
                    err_count++;
                end else begin
                    want = solved_q.pop_front();
                    if (got.face !== want.face) begin
                        $error("face_tag expected %h actual %h", want.face, got.face);
                        err_count++;
                    end
                    if (got.idx !== want.idx) begin
                        $error("species_index expected %0d actual %0d", want.idx, got.idx);
                        err_count++;
                    end
                    if (got.nx !== want.nx) begin
                        $error("new_x expected %h actual %h", want.nx, got.nx);
                        err_count++;
                    end
                    if (got.nw !== want.nw) begin
                        $error("new_w expected %h actual %h", want.nw, got.nw);
                        err_count++;
                    end
                    if (got.conv !== want.conv) begin
                        $error("converged expected %b actual %b", want.conv, got.conv);
                        err_count++;
                    end
                    if (got.fin !== want.fin) begin
                        $error("final_res expected %b actual %b", want.fin, got.fin);
                        err_count++;
                    end
                end
            end
        end
    end

    // Drive result-side backpressure; a requested long hold starts once a result waits
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && m_axis_tvalid) begin
            hold_req <= 0;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Offer one species transaction and hold it until accepted
    task automatic send_row(row_t r);
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        cur_row = r;
        s_axis_tdata <= {r.item.sat, r.item.mw, r.item.mx, r.item.face};
        s_axis_tuser <= r.item.opcode;
        s_axis_tlast <= r.item.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        if (r.item.last) faces_sent++;
    endtask

    task automatic send_item(species_t it);
        row_t r;
        r.item = it;
        r.typed = 0;
        r.want = '{default: '0};
        send_row(r);
    endtask

    // Drain outstanding results before touching registers
    task automatic wait_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (solved_q.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == {REG_TOLERANCE, 2'b00}) eq_tol = data[28:0];
        else eq_maxit = data[15:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] rand_frac();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(32'h2000_0000) - 32'h1000_0000;
    endfunction

    function automatic logic [31:0] rand_sat();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(32'h0003_0000, 32'h0000_4000);
    endfunction

    // Build one face: active and inactive species in random order, last on the final one
    task automatic send_face();
        species_t list[$];
        species_t it;
        int n_act, n_inact, k, pick;
        logic [15:0] face;
        pick = $urandom_range(99);
        if (pick < 15) n_act = 0;
        else if (pick < 85) n_act = $urandom_range(4, 1);
        else if (pick < 95) n_act = $urandom_range(8, 5);
        else n_act = $urandom_range(11, 9);
        n_inact = $urandom_range(3);
        if (n_act + n_inact == 0) n_inact = 1;
        face = 16'($urandom);
        for (int i = 0; i < n_act + n_inact; i++) begin
            it.opcode = (i < n_act) ? OP_ACTIVE : OP_INACTIVE;
            it.face = face;
            it.mx = rand_frac();
            it.mw = rand_frac();
            it.sat = rand_sat();
            it.last = 1'b0;
            list.push_back(it);
        end
        list.shuffle();
        list[list.size() - 1].last = 1'b1;
        // occasional stray face number on a leading item
        if ($urandom_range(3) == 0) list[0].face = 16'($urandom);
        for (k = 0; k < list.size(); k++) send_item(list[k]);
    endtask

    task automatic random_phase(int sidle, int ridle, bit pressure, int target);
        int start;
        snd_idle = sidle;
        rcv_idle = ridle;
        reg_write({REG_TOLERANCE, 2'b00}, ($urandom_range(2) == 0) ? 32'd0 :
                  ($urandom_range(1) ? $urandom_range(32'h0010_0000) : $urandom_range(32'd5000)));
        reg_write({REG_MAX_ITER, 2'b00}, $urandom_range(6, 1));
        if (pressure) hold_req = 1;
        start = items_sent;
        while (items_sent - start < target) send_face();
        wait_idle();
    endtask

    function automatic row_t mk(logic op, logic [15:0] f, logic [31:0] x, logic [31:0] w,
                                logic [31:0] s, logic l);
        row_t r;
        r.item = '{op, f, x, w, s, l};
        r.typed = 0;
        r.want = '{default: '0};
        return r;
    endfunction

    initial begin
        row_t table_a[$];
        row_t table_b[$];
        row_t r;
        logic [31:0] x0, w0;

        eq_count = 0;
        eq_inact = 0;
        eq_face = '0;
        eq_tol = TOL_RESET;
        eq_maxit = ITER_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty face, then a trivially converged species
        snd_idle = 0;
        rcv_idle = 0;
        r = mk(OP_INACTIVE, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        r.typed = 1;
        r.want = '{16'hFFFF, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1};
        table_a.push_back(r);
        r = mk(OP_ACTIVE, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b1);
        r.typed = 1;
        r.want = '{16'h0000, 3'd0, 32'd0, 32'd0, 1'b1, 1'b1};
        table_a.push_back(r);
        foreach (table_a[i]) send_row(table_a[i]);
        wait_idle();

        // zero tolerance, two rounds: extremes, inactive sum, divide by zero, overflow
        reg_write({REG_TOLERANCE, 2'b00}, 32'd0);
        reg_write({REG_MAX_ITER, 2'b00}, 32'd2);
        table_b.push_back(mk(OP_ACTIVE, 16'h1234, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'hFFFF_FFFF, 1'b0));
        table_b.push_back(mk(OP_ACTIVE, 16'h1234, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b0));
        table_b.push_back(mk(OP_INACTIVE, 16'h1234, 32'h7FFF_FFFF, 32'h5555_5555, 32'h1, 1'b0));
        table_b.push_back(mk(OP_INACTIVE, 16'h1234, 32'h8000_0000, 32'hAAAA_AAAA, 32'h2, 1'b0));
        table_b.push_back(mk(OP_ACTIVE, 16'h4321, 32'h0400_0000, 32'h0200_0000,
                             32'h0001_0000, 1'b1));
        table_b.push_back(mk(OP_ACTIVE, 16'h00AA, 32'h1000_0000, 32'hF000_0000,
                             32'h0001_0000, 1'b1));
        table_b.push_back(mk(OP_ACTIVE, 16'h0055, 32'hF000_0000, 32'h1000_0000,
                             32'h0001_0000, 1'b1));
        for (int i = 0; i < 9; i++)
            table_b.push_back(mk(OP_ACTIVE, 16'(16'h0900 + i), 32'h0100_0000 * (i + 1),
                                 32'h0080_0000, 32'h0000_8000 + 32'h1000 * i, 1'b0));
        table_b.push_back(mk(OP_INACTIVE, 16'h0999, 32'h0800_0000, 32'd0, 32'd0, 1'b1));
        foreach (table_b[i]) send_row(table_b[i]);
        wait_idle();

        // no rounds at all: loaded values come straight back, not converged
        reg_write({REG_TOLERANCE, 2'b00}, 32'd268435456);
        reg_write({REG_MAX_ITER, 2'b00}, 32'd0);
        x0 = $urandom;
        w0 = $urandom;
        r = mk(OP_ACTIVE, 16'hBEEF, x0, w0, $urandom, 1'b1);
        r.typed = 1;
        r.want = '{16'hBEEF, 3'd0, x0, w0, 1'b0, 1'b1};
        send_row(r);
        wait_idle();

        // widest round limit with zero fractions converges in the first round
        reg_write({REG_MAX_ITER, 2'b00}, 32'd65535);
        r = mk(OP_ACTIVE, 16'hCAFE, 32'd0, 32'd0, $urandom, 1'b1);
        r.typed = 1;
        r.want = '{16'hCAFE, 3'd0, 32'd0, 32'd0, 1'b1, 1'b1};
        send_row(r);
        wait_idle();

        // random faces under three idling patterns
        random_phase(9, 45, 1, 45);
        random_phase(45, 9, 0, 45);
        random_phase(0, 0, 0, 45);

        if (solved_q.size() != 0) begin
            $error("%0d expected results never arrived", solved_q.size());
            err_count++;
        end
        $display("Covered %0d species transactions in %0d faces, %0d results checked,",
                 items_sent, faces_sent, results_seen);
        $display("with register sweeps, overflowed stores and a long output stall.");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop on a hang
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
